>>> rtl/core/gpc_pkg.sv
package gpc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int THR_W            = 16;
  localparam int LEN_W            = 8;
  localparam int CLS_W            = 2;
  localparam int CFG_AW           = 5;
  localparam int CFG_DW           = 32;

  localparam logic [THR_W-1:0] START_DELTA_RST  = 16'd768;
  localparam logic [THR_W-1:0] WALK_MIN_RST     = 16'd1280;
  localparam logic [THR_W-1:0] RUN_MIN_RST      = 16'd3584;
  localparam logic [THR_W-1:0] HOP_RATE_MIN_RST = 16'd1138;
  localparam logic [LEN_W-1:0] PEAK_LIMIT_RST   = 8'd30;

  typedef enum logic [2:0] {
    REG_START_DELTA  = 3'd0,
    REG_WALK_MIN     = 3'd1,
    REG_RUN_MIN      = 3'd2,
    REG_HOP_RATE_MIN = 3'd3,
    REG_PEAK_LIMIT   = 3'd4
  } reg_idx_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_NONE = 2'd0,
    CLS_WALK = 2'd1,
    CLS_RUN  = 2'd2,
    CLS_HOP  = 2'd3
  } step_class_t;

endpackage

>>> rtl/core/gpc_if.sv
interface gpc_in_if
  import gpc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] vert_accel;
  logic signed [SAMPLE_WIDTH-1:0] yaw_rate;

  modport source (output valid, vert_accel, yaw_rate, input ready);
  modport sink   (input valid, vert_accel, yaw_rate, output ready);
endinterface

interface gpc_out_if
  import gpc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CLS_W-1:0] step_class;
  logic             peak_closed;

  modport source (output valid, step_class, peak_closed, input ready);
  modport sink   (input valid, step_class, peak_closed, output ready);
endinterface

>>> rtl/core/gait_peak_classifier.sv
// An input transfer reaches out_ch through the input register, then through one
//   compare/max/classify stage into the result register.
// Throughput: one sample per cycle if out_ch is ready; peak state moves per sample.
// A stalled result blocks the input only once the input register is also full.
// Reset (rst_n low, synchronous): idle phase, previous sample and peak state cleared,
//   configuration registers back to their defaults, both pipeline stages emptied.
module gait_peak_classifier
  import gpc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gpc_in_if.sink            in_ch,
  gpc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int DW = W + 1;
  localparam int MW = (W > THR_W) ? W : THR_W;
  localparam int CW = (DW > THR_W) ? DW : THR_W;

  // configuration
  logic [THR_W-1:0] start_delta_r, walk_min_r, run_min_r, hop_rate_min_r;
  logic [LEN_W-1:0] peak_limit_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  // pipeline
  logic                s1_valid_r, s1_valid_nxt;
  logic signed [W-1:0] s1_vert_r, s1_rate_r;
  logic                out_valid_r, out_valid_nxt;
  step_class_t         out_cls_r, out_cls_nxt;
  logic                out_closed_r, out_closed_nxt;
  logic                in_xfer, out_load, advance;

  // peak state
  logic                in_peak_r, in_peak_nxt;
  logic signed [W-1:0] prev_vert_r, prev_vert_nxt;
  logic [LEN_W-1:0]    peak_length_r, peak_length_nxt;
  logic [W-1:0]        vert_peak_mag_r, vert_peak_mag_nxt;
  logic [W-1:0]        rate_peak_mag_r, rate_peak_mag_nxt;

  // datapath
  logic signed [DW-1:0] delta;
  logic [DW-1:0]        delta_mag;
  logic [W-1:0]         vert_mag, rate_mag, vmag_upd, rmag_upd;
  logic [LEN_W:0]       len_inc;
  logic                 open_peak, close_peak;
  step_class_t          cls;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_START_DELTA:  prdata = CFG_DW'(start_delta_r);
      REG_WALK_MIN:     prdata = CFG_DW'(walk_min_r);
      REG_RUN_MIN:      prdata = CFG_DW'(run_min_r);
      REG_HOP_RATE_MIN: prdata = CFG_DW'(hop_rate_min_r);
      REG_PEAK_LIMIT:   prdata = CFG_DW'(peak_limit_r);
      default:          prdata = '0;
    endcase
  end

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_load     = !out_valid_r || out_ch.ready;
  assign advance      = s1_valid_r && out_load;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign s1_valid_nxt = in_xfer || (s1_valid_r && !advance);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.step_class  = out_cls_r;
  assign out_ch.peak_closed = out_closed_r;

  always_comb begin
    delta     = {s1_vert_r[W-1], s1_vert_r} - {prev_vert_r[W-1], prev_vert_r};
    delta_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);
    vert_mag  = s1_vert_r[W-1] ? W'(-s1_vert_r) : W'(s1_vert_r);
    rate_mag  = s1_rate_r[W-1] ? W'(-s1_rate_r) : W'(s1_rate_r);
    open_peak = CW'(delta_mag) > CW'(start_delta_r);
    vmag_upd  = (vert_mag > vert_peak_mag_r) ? vert_mag : vert_peak_mag_r;
    rmag_upd  = (rate_mag > rate_peak_mag_r) ? rate_mag : rate_peak_mag_r;
    len_inc   = {1'b0, peak_length_r} + (LEN_W+1)'(1);
    // close on timeout or on a falling sample below zero
    close_peak = (len_inc > {1'b0, peak_limit_r}) ||
                 ((s1_vert_r < prev_vert_r) && s1_vert_r[W-1]);

    priority if (MW'(vmag_upd) < MW'(walk_min_r)) begin
      cls = CLS_NONE;
    end else if (MW'(vmag_upd) < MW'(run_min_r)) begin
      cls = CLS_WALK;
    end else if (MW'(rmag_upd) > MW'(hop_rate_min_r)) begin
      cls = CLS_HOP;
    end else begin
      cls = CLS_RUN;
    end

    in_peak_nxt       = in_peak_r;
    prev_vert_nxt     = prev_vert_r;
    peak_length_nxt   = peak_length_r;
    vert_peak_mag_nxt = vert_peak_mag_r;
    rate_peak_mag_nxt = rate_peak_mag_r;
    out_cls_nxt       = CLS_NONE;
    out_closed_nxt    = 1'b0;

    if (advance) begin
      prev_vert_nxt = s1_vert_r;
      if (!in_peak_r) begin
        if (open_peak) begin
          in_peak_nxt       = 1'b1;
          peak_length_nxt   = LEN_W'(1);
          vert_peak_mag_nxt = vert_mag;
          rate_peak_mag_nxt = rate_mag;
        end
      end else begin
        vert_peak_mag_nxt = vmag_upd;
        rate_peak_mag_nxt = rmag_upd;
        // saturate the stored count
        peak_length_nxt   = len_inc[LEN_W] ? '1 : len_inc[LEN_W-1:0];
        if (close_peak) begin
          in_peak_nxt    = 1'b0;
          out_cls_nxt    = cls;
          out_closed_nxt = 1'b1;
        end
      end
    end

    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delta_r   <= START_DELTA_RST;
      walk_min_r      <= WALK_MIN_RST;
      run_min_r       <= RUN_MIN_RST;
      hop_rate_min_r  <= HOP_RATE_MIN_RST;
      peak_limit_r    <= PEAK_LIMIT_RST;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      in_peak_r       <= 1'b0;
      prev_vert_r     <= '0;
      peak_length_r   <= '0;
      vert_peak_mag_r <= '0;
      rate_peak_mag_r <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_START_DELTA:  start_delta_r  <= pwdata[THR_W-1:0];
          REG_WALK_MIN:     walk_min_r     <= pwdata[THR_W-1:0];
          REG_RUN_MIN:      run_min_r      <= pwdata[THR_W-1:0];
          REG_HOP_RATE_MIN: hop_rate_min_r <= pwdata[THR_W-1:0];
          REG_PEAK_LIMIT:   peak_limit_r   <= pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
      in_peak_r       <= in_peak_nxt;
      prev_vert_r     <= prev_vert_nxt;
      peak_length_r   <= peak_length_nxt;
      vert_peak_mag_r <= vert_peak_mag_nxt;
      rate_peak_mag_r <= rate_peak_mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_vert_r <= in_ch.vert_accel;
      s1_rate_r <= in_ch.yaw_rate;
    end
    if (out_load) begin
      out_cls_r    <= out_cls_nxt;
      out_closed_r <= out_closed_nxt;
    end
  end

  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_peak_r) |-> (out_valid_r && out_closed_r))
    else $error("peak closed without a closing result");

  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_peak_r |-> (peak_length_r != '0))
    else $error("open peak with zero length");

  a_no_close_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_closed_r) |-> (out_cls_r == CLS_NONE))
    else $error("class reported without a closed peak");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages are stalled");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance) && $past(rst_n) |-> $stable(in_peak_r) && $stable(prev_vert_r))
    else $error("peak state moved without a sample");

endmodule
